### rtl/bgf_pkg.sv
// ============================================================================
// bgf_pkg
// Shared widths, constants, command and status types and the charge table
// of the battery gauge filter and lookup unit.
// ============================================================================
`default_nettype none

package bgf_pkg;

    localparam int ADC_BITS     = 12;
    localparam int VOLT_W       = 19;
    localparam int PCT_W        = 7;
    localparam int LOOK_W       = 16;
    localparam int DIVISOR_W    = 8;
    localparam int TABLE_POINTS = 17;
    localparam int SEG_W        = $clog2(TABLE_POINTS + 1);

    // Full scale of the converter and the scale factor 3.3 V * 11 in 0.1 mV.
    localparam int ADC_FULL = (1 << ADC_BITS) - 1;
    localparam logic [VOLT_W-1:0] SCALE_K = VOLT_W'(33000 * 11);
    localparam int PROD_W = ADC_BITS + VOLT_W;

    localparam logic [DIVISOR_W-1:0] DIVISOR_RESET = DIVISOR_W'(8);

    // Table spans are at most 1000, so the offset into a span fits 10 bits.
    localparam int DIFF_W = 10;

    // Shared serial divider.
    localparam int DIV_NUM_W = VOLT_W;
    localparam int DIV_DEN_W = 10;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    typedef struct packed {
        logic load_sample;
        logic scale_mul;
        logic scale_est;
        logic scale_fix;
        logic filt_load;
        logic filt_start;
        logic filt_upd;
        logic look_search;
        logic look_mul;
        logic look_start;
        logic out_load;
    } bgf_cmd_t;

    typedef struct packed {
        logic y_zero;
        logic div_busy;
        logic seg_interior;
    } bgf_status_t;

    function automatic logic [LOOK_W-1:0] gauge_mv(input logic [SEG_W-1:0] idx);
        logic [LOOK_W-1:0] mv;
        unique case (idx)
            SEG_W'(0):  mv = LOOK_W'(42000);
            SEG_W'(1):  mv = LOOK_W'(41500);
            SEG_W'(2):  mv = LOOK_W'(41000);
            SEG_W'(3):  mv = LOOK_W'(40500);
            SEG_W'(4):  mv = LOOK_W'(40000);
            SEG_W'(5):  mv = LOOK_W'(39500);
            SEG_W'(6):  mv = LOOK_W'(39000);
            SEG_W'(7):  mv = LOOK_W'(38500);
            SEG_W'(8):  mv = LOOK_W'(38000);
            SEG_W'(9):  mv = LOOK_W'(37500);
            SEG_W'(10): mv = LOOK_W'(37000);
            SEG_W'(11): mv = LOOK_W'(36500);
            SEG_W'(12): mv = LOOK_W'(36000);
            SEG_W'(13): mv = LOOK_W'(35500);
            SEG_W'(14): mv = LOOK_W'(35000);
            SEG_W'(15): mv = LOOK_W'(34000);
            SEG_W'(16): mv = LOOK_W'(33000);
            default:    mv = '0;
        endcase
        return mv;
    endfunction

    function automatic logic [PCT_W-1:0] gauge_pct(input logic [SEG_W-1:0] idx);
        logic [PCT_W-1:0] pct;
        unique case (idx)
            SEG_W'(0):  pct = PCT_W'(100);
            SEG_W'(1):  pct = PCT_W'(95);
            SEG_W'(2):  pct = PCT_W'(90);
            SEG_W'(3):  pct = PCT_W'(85);
            SEG_W'(4):  pct = PCT_W'(80);
            SEG_W'(5):  pct = PCT_W'(75);
            SEG_W'(6):  pct = PCT_W'(70);
            SEG_W'(7):  pct = PCT_W'(65);
            SEG_W'(8):  pct = PCT_W'(60);
            SEG_W'(9):  pct = PCT_W'(55);
            SEG_W'(10): pct = PCT_W'(45);
            SEG_W'(11): pct = PCT_W'(35);
            SEG_W'(12): pct = PCT_W'(25);
            SEG_W'(13): pct = PCT_W'(15);
            SEG_W'(14): pct = PCT_W'(8);
            SEG_W'(15): pct = PCT_W'(3);
            SEG_W'(16): pct = PCT_W'(0);
            default:    pct = '0;
        endcase
        return pct;
    endfunction

endpackage

`default_nettype wire

### rtl/bgf_divider.sv
// ============================================================================
// bgf_divider
// Restoring serial divider, one quotient bit per cycle, shared by the
// smoothing filter and the table interpolation.
// ============================================================================
`default_nettype none

module bgf_divider (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [bgf_pkg::DIV_NUM_W-1:0]  num,
    input  wire logic [bgf_pkg::DIV_DEN_W-1:0]  den,
    output logic                                busy,
    output logic [bgf_pkg::DIV_NUM_W-1:0]       quo
);

    logic                              busy_reg;
    logic                              busy_next;
    logic [bgf_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [bgf_pkg::DIV_CNT_W-1:0]     cnt_next;
    logic [bgf_pkg::DIV_NUM_W-1:0]     quo_reg;
    logic [bgf_pkg::DIV_NUM_W-1:0]     quo_next;
    logic [bgf_pkg::DIV_DEN_W-1:0]     rem_reg;
    logic [bgf_pkg::DIV_DEN_W-1:0]     rem_next;
    logic [bgf_pkg::DIV_DEN_W-1:0]     den_reg;
    logic [bgf_pkg::DIV_DEN_W-1:0]     den_next;
    logic [bgf_pkg::DIV_DEN_W:0]       shifted;
    logic [bgf_pkg::DIV_DEN_W:0]       trial;
    logic                              fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[bgf_pkg::DIV_NUM_W-1]};
        trial   = shifted - {1'b0, den_reg};
        fits    = shifted >= {1'b0, den_reg};

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = bgf_pkg::DIV_CNT_W'(bgf_pkg::DIV_NUM_W);
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            // The remainder always stays below the divisor, so it fits.
            rem_next = fits ? trial[bgf_pkg::DIV_DEN_W-1:0]
                            : shifted[bgf_pkg::DIV_DEN_W-1:0];
            quo_next = {quo_reg[bgf_pkg::DIV_NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == bgf_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

### rtl/bgf_datapath.sv
// ============================================================================
// bgf_datapath
// Sample scaling, smoothing filter state, table search and interpolation,
// the divisor register and the result register.
// ============================================================================
`default_nettype none

module bgf_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire bgf_pkg::bgf_cmd_t                 cmd,
    output bgf_pkg::bgf_status_t                   status,
    input  wire logic                              cfg_we,
    input  wire logic [bgf_pkg::DIVISOR_W-1:0]     cfg_data,
    input  wire logic [bgf_pkg::ADC_BITS-1:0]      sample,
    output logic [bgf_pkg::VOLT_W-1:0]             volt_out,
    output logic [bgf_pkg::PCT_W-1:0]              pct_out
);

    localparam int EST_W = bgf_pkg::PROD_W + 1;

    logic [bgf_pkg::DIVISOR_W-1:0]  div_cfg_reg;
    logic [bgf_pkg::VOLT_W-1:0]     y_reg;
    logic [bgf_pkg::VOLT_W-1:0]     y_next;

    logic [bgf_pkg::ADC_BITS-1:0]   sample_reg;
    logic [bgf_pkg::PROD_W-1:0]     prod_reg;
    logic [bgf_pkg::VOLT_W-1:0]     est_reg;
    logic [bgf_pkg::VOLT_W-1:0]     v_reg;
    logic                           up_reg;
    logic [bgf_pkg::LOOK_W-1:0]     look_reg;
    logic [bgf_pkg::SEG_W-1:0]      seg_reg;
    logic [bgf_pkg::DIV_NUM_W-1:0]  num_reg;
    logic [bgf_pkg::VOLT_W-1:0]     volt_reg;
    logic [bgf_pkg::PCT_W-1:0]      pct_reg;

    logic [EST_W-1:0]               est_sum;
    logic [bgf_pkg::PROD_W-1:0]     back;
    logic [bgf_pkg::PROD_W-1:0]     resid;
    logic [bgf_pkg::VOLT_W-1:0]     v_fixed;
    logic                           v_ge_y;
    logic [bgf_pkg::VOLT_W-1:0]     filt_diff;
    logic [bgf_pkg::DIVISOR_W-1:0]  divisor;
    logic [bgf_pkg::LOOK_W-1:0]     look;
    logic [bgf_pkg::SEG_W-1:0]      seg_found;
    logic [bgf_pkg::SEG_W-1:0]      seg_prev;
    logic                           seg_interior;
    logic [bgf_pkg::LOOK_W-1:0]     span_full;
    logic [bgf_pkg::LOOK_W-1:0]     offset_full;
    logic [bgf_pkg::PCT_W-1:0]      dp;
    logic [bgf_pkg::DIFF_W+bgf_pkg::PCT_W-1:0] interp_prod;
    logic [bgf_pkg::PCT_W-1:0]      pct_next;

    logic                           div_start;
    logic [bgf_pkg::DIV_NUM_W-1:0]  div_num;
    logic [bgf_pkg::DIV_DEN_W-1:0]  div_den;
    logic                           div_busy;
    logic [bgf_pkg::DIV_NUM_W-1:0]  div_quo;

    // Division by 2^B - 1: the sum p + p/2^B + p/2^2B shifted down by B bits
    // is at most one below the true quotient; one compare fixes it.
    always_comb
    begin
        est_sum = EST_W'(prod_reg)
                + EST_W'(prod_reg >> bgf_pkg::ADC_BITS)
                + EST_W'(prod_reg >> (2 * bgf_pkg::ADC_BITS));
        back    = (bgf_pkg::PROD_W'(est_reg) << bgf_pkg::ADC_BITS)
                - bgf_pkg::PROD_W'(est_reg);
        resid   = prod_reg - back;
        v_fixed = (resid >= bgf_pkg::PROD_W'(bgf_pkg::ADC_FULL)) ? est_reg + 1'b1 : est_reg;
    end

    always_comb
    begin
        v_ge_y    = v_reg >= y_reg;
        filt_diff = v_ge_y ? v_reg - y_reg : y_reg - v_reg;
        divisor   = (div_cfg_reg == '0) ? bgf_pkg::DIVISOR_W'(1) : div_cfg_reg;
    end

    // The first table point at or below the voltage; past the end means
    // below the table.
    always_comb
    begin
        look = (y_reg > bgf_pkg::VOLT_W'({bgf_pkg::LOOK_W{1'b1}}))
             ? {bgf_pkg::LOOK_W{1'b1}} : y_reg[bgf_pkg::LOOK_W-1:0];
        seg_found = bgf_pkg::SEG_W'(bgf_pkg::TABLE_POINTS);
        for (int i = bgf_pkg::TABLE_POINTS - 1; i >= 0; i--)
        begin
            if (look >= bgf_pkg::gauge_mv(bgf_pkg::SEG_W'(i)))
            begin
                seg_found = bgf_pkg::SEG_W'(i);
            end
        end
    end

    always_comb
    begin
        seg_prev     = seg_reg - 1'b1;
        seg_interior = (seg_reg != '0)
                    && (seg_reg != bgf_pkg::SEG_W'(bgf_pkg::TABLE_POINTS));
        span_full    = bgf_pkg::gauge_mv(seg_prev) - bgf_pkg::gauge_mv(seg_reg);
        offset_full  = look_reg - bgf_pkg::gauge_mv(seg_reg);
        dp           = bgf_pkg::gauge_pct(seg_prev) - bgf_pkg::gauge_pct(seg_reg);
        interp_prod  = {{bgf_pkg::PCT_W{1'b0}}, offset_full[bgf_pkg::DIFF_W-1:0]}
                     * {{bgf_pkg::DIFF_W{1'b0}}, dp};
    end

    always_comb
    begin
        if (seg_reg == '0)
        begin
            pct_next = bgf_pkg::gauge_pct(seg_reg);
        end
        else if (seg_interior)
        begin
            pct_next = bgf_pkg::gauge_pct(seg_reg) + div_quo[bgf_pkg::PCT_W-1:0];
        end
        else
        begin
            pct_next = '0;
        end
    end

    always_comb
    begin
        div_start = cmd.filt_start | cmd.look_start;
        div_num   = cmd.filt_start ? filt_diff : num_reg;
        div_den   = cmd.filt_start ? bgf_pkg::DIV_DEN_W'(divisor)
                                   : span_full[bgf_pkg::DIV_DEN_W-1:0];
    end

    always_comb
    begin
        y_next = y_reg;
        if (cmd.filt_load)
        begin
            y_next = v_reg;
        end
        else if (cmd.filt_upd)
        begin
            y_next = up_reg ? y_reg + div_quo : y_reg - div_quo;
        end
    end

    bgf_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cfg_reg <= bgf_pkg::DIVISOR_RESET;
            y_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                div_cfg_reg <= cfg_data;
            end
            y_reg <= y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            sample_reg <= sample;
        end
        if (cmd.scale_mul)
        begin
            prod_reg <= bgf_pkg::PROD_W'(sample_reg) * bgf_pkg::PROD_W'(bgf_pkg::SCALE_K);
        end
        if (cmd.scale_est)
        begin
            est_reg <= bgf_pkg::VOLT_W'(est_sum >> bgf_pkg::ADC_BITS);
        end
        if (cmd.scale_fix)
        begin
            v_reg <= v_fixed;
        end
        if (cmd.filt_start)
        begin
            up_reg <= v_ge_y;
        end
        if (cmd.look_search)
        begin
            look_reg <= look;
            seg_reg  <= seg_found;
        end
        if (cmd.look_mul)
        begin
            num_reg <= bgf_pkg::DIV_NUM_W'(interp_prod);
        end
        if (cmd.out_load)
        begin
            volt_reg <= y_reg;
            pct_reg  <= pct_next;
        end
    end

    always_comb
    begin
        status.y_zero       = y_reg == '0;
        status.div_busy     = div_busy;
        status.seg_interior = seg_interior;
    end

    assign volt_out = volt_reg;
    assign pct_out  = pct_reg;

endmodule

`default_nettype wire

### rtl/bgf_ctrl.sv
// ============================================================================
// bgf_ctrl
// Sequencer of the gauge: steps one request through scaling, filtering
// and lookup, and owns the input and output handshakes.
// ============================================================================
`default_nettype none

module bgf_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    input  wire bgf_pkg::bgf_status_t   status,
    output bgf_pkg::bgf_cmd_t           cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_MUL    = 4'd1;
    localparam logic [3:0] ST_EST    = 4'd2;
    localparam logic [3:0] ST_FIX    = 4'd3;
    localparam logic [3:0] ST_FILT   = 4'd4;
    localparam logic [3:0] ST_FWAIT  = 4'd5;
    localparam logic [3:0] ST_SEARCH = 4'd6;
    localparam logic [3:0] ST_LMUL   = 4'd7;
    localparam logic [3:0] ST_LDIV   = 4'd8;
    localparam logic [3:0] ST_LWAIT  = 4'd9;
    localparam logic [3:0] ST_DONE   = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_sample = 1'b1;
                    state_next      = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.scale_mul = 1'b1;
                state_next    = ST_EST;
            end
            ST_EST:
            begin
                cmd.scale_est = 1'b1;
                state_next    = ST_FIX;
            end
            ST_FIX:
            begin
                cmd.scale_fix = 1'b1;
                state_next    = ST_FILT;
            end
            ST_FILT:
            begin
                // An empty filter takes the scaled sample as it is.
                if (status.y_zero)
                begin
                    cmd.filt_load = 1'b1;
                    state_next    = ST_SEARCH;
                end
                else
                begin
                    cmd.filt_start = 1'b1;
                    state_next     = ST_FWAIT;
                end
            end
            ST_FWAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.filt_upd = 1'b1;
                    state_next   = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                cmd.look_search = 1'b1;
                state_next      = ST_LMUL;
            end
            ST_LMUL:
            begin
                cmd.look_mul = 1'b1;
                state_next   = ST_LDIV;
            end
            ST_LDIV:
            begin
                if (status.seg_interior)
                begin
                    cmd.look_start = 1'b1;
                    state_next     = ST_LWAIT;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_LWAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

### rtl/battery_gauge_filter_lut_unit.sv
// ============================================================================
// battery_gauge_filter_lut_unit
// Battery gauge: converter sample scaling, smoothing filter and
// piecewise linear charge lookup.
// ============================================================================
// Usage:
// A request carries one raw converter sample on adc_sample (in_valid /
// in_ready). Each request gives one result, filtered_voltage in 0.1 mV
// units and charge_percent, on out_valid / out_ready.
// The block works on one request at a time. The filter pass of the
// shared serial divider is skipped when the filter is loaded outright,
// and the lookup pass when the voltage lies at or above the first table
// point or below the last. The divider yields one quotient bit per cycle
// over 19 bits. in_ready is high again from the cycle in which out_valid
// rises, so a new request can enter while that result waits.
// When the receiver stalls, the finished result waits in the output
// register and the next request stops just before loading its own.
// The divisor port (cfg_valid / cfg_ready, filter_divisor) is always
// ready. Reset empties the filter and sets the divisor to 8.
// ============================================================================
`default_nettype none

module battery_gauge_filter_lut_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [bgf_pkg::ADC_BITS-1:0]       adc_sample,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [bgf_pkg::VOLT_W-1:0]              filtered_voltage,
    output logic [bgf_pkg::PCT_W-1:0]               charge_percent,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [bgf_pkg::DIVISOR_W-1:0]      filter_divisor
);

    bgf_pkg::bgf_cmd_t    cmd;
    bgf_pkg::bgf_status_t status;
    logic                 cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;

    bgf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    bgf_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .cfg_we   (cfg_we),
        .cfg_data (filter_divisor),
        .sample   (adc_sample),
        .volt_out (filtered_voltage),
        .pct_out  (charge_percent)
    );

endmodule

`default_nettype wire
